// File: src/lht_pkg.sv
// Shared constants, codes and types of the linear hash table.
// Depends on nothing; lht_ifs, lht_div and the core import it.
`default_nettype none
package lht_pkg;
  localparam int MAX_BUCKETS = 1024;
  localparam int SLOTS = 32;
  localparam int BKT_W = 10;
  localparam int SLOT_W = 5;
  localparam int ADDR_W = BKT_W + SLOT_W;
  localparam int KEY_W = 64;
  localparam int VAL_W = 32;
  localparam int NB_W = 11;
  localparam int FILL_W = 6;
  localparam int CNT_W = 16;
  localparam int STORE_DEPTH = MAX_BUCKETS * SLOTS;

  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [0:0] REG_INIT_BUCKETS = 1'd0;
  localparam logic [0:0] REG_CAPACITY = 1'd1;

  localparam logic [NB_W-1:0] RESET_BUCKETS = 11'd100;
  localparam logic [FILL_W-1:0] RESET_CAPACITY = 6'd32;

  typedef struct packed {
    logic done;
    logic q_lsb;
    logic [NB_W-1:0] rem;
  } div_res_t;
endpackage
`default_nettype wire

// File: src/lht_ifs.sv
// Item channel interfaces of the linear hash table: request and result.
// Depends on lht_pkg.
`default_nettype none
interface lht_in_if import lht_pkg::*;;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  modport source(output valid, operation, key, value, input ready);
  modport sink(input valid, operation, key, value, output ready);
endinterface

interface lht_out_if import lht_pkg::*;;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [VAL_W-1:0] value_out;
  logic replaced;
  logic [NB_W-1:0] level_buckets;
  logic [BKT_W-1:0] split_pointer;
  logic [CNT_W-1:0] live_items;
  modport source(output valid, status, value_out, replaced, level_buckets, split_pointer,
                 live_items, input ready);
  modport sink(input valid, status, value_out, replaced, level_buckets, split_pointer,
               live_items, output ready);
endinterface
`default_nettype wire

// File: src/lht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/lht_div.sv
// Bit-serial remainder unit: key mod N and the low quotient bit, one bit a cycle.
// Depends on lht_pkg.
`default_nettype none
module lht_div import lht_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] dividend,
  input  wire logic [NB_W-1:0]  divisor,
  output div_res_t              res
);
  logic busy;
  logic done;
  logic [5:0] cnt;
  logic [KEY_W-1:0] sh;
  logic [NB_W-1:0] rem;
  logic q;
  logic [NB_W:0] trial;
  logic [NB_W:0] diff;

  assign trial = {rem, sh[KEY_W-1]};
  assign diff = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      rem <= '0;
      q <= 1'b0;
    end else if (busy) begin
      sh <= {sh[KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[NB_W-1:0];
        q <= 1'b1;
      end else begin
        rem <= trial[NB_W-1:0];
        q <= 1'b0;
      end
    end
  end

  assign res.done = done;
  assign res.q_lsb = q;
  assign res.rem = rem;
endmodule
`default_nettype wire

// File: src/linear_hash_table_core.sv
// Linear-hashing key/value table: a sequencer around one bit-serial remainder unit.
// Block use: requests come in on in_ch (operation, key, value), one result leaves
// on out_ch per request, and two configuration registers are written over a plain
// port (cfg_we, cfg_index, cfg_data). Index 0 sets the starting bucket count and
// empties the table; index 1 sets the bucket capacity and keeps the contents.
// One item is taken at a time; in_ch.ready is high only while the block is idle.
// Every request first runs the remainder unit to find its bucket, then a binary search
// of up to six probes, each through the states S_BSC, S_BSW and S_BSM. A remove
// or an inserting put then shifts the entries behind its slot one by one. A put
// into a full bucket first splits a bucket, one remainder pass per entry of that
// bucket, then runs one more bucket lookup.
// The result is held on out_ch until taken; a stalled receiver holds the block.
// After reset, and after each write to register 0, a clearing pass zeroes the
// 1024 bucket fill counts, one per cycle, and no item is taken until it ends.
// Depends on lht_pkg, lht_ifs, lht_ram and lht_div.
`default_nettype none
module linear_hash_table_core import lht_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  lht_in_if.sink                 in_ch,
  lht_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [NB_W-1:0]   cfg_data
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_DIV  = 5'd2;
  localparam logic [4:0] S_FW   = 5'd3;
  localparam logic [4:0] S_FCHK = 5'd4;
  localparam logic [4:0] S_SPFW = 5'd5;
  localparam logic [4:0] S_SPF  = 5'd6;
  localparam logic [4:0] S_SPL  = 5'd7;
  localparam logic [4:0] S_SPW  = 5'd8;
  localparam logic [4:0] S_SPD  = 5'd9;
  localparam logic [4:0] S_SPDV = 5'd10;
  localparam logic [4:0] S_SPE  = 5'd11;
  localparam logic [4:0] S_BSC  = 5'd12;
  localparam logic [4:0] S_BSW  = 5'd13;
  localparam logic [4:0] S_BSM  = 5'd14;
  localparam logic [4:0] S_FND  = 5'd15;
  localparam logic [4:0] S_GW   = 5'd16;
  localparam logic [4:0] S_GR   = 5'd17;
  localparam logic [4:0] S_RML  = 5'd18;
  localparam logic [4:0] S_RMW  = 5'd19;
  localparam logic [4:0] S_RMP  = 5'd20;
  localparam logic [4:0] S_NF   = 5'd21;
  localparam logic [4:0] S_INL  = 5'd22;
  localparam logic [4:0] S_INW  = 5'd23;
  localparam logic [4:0] S_INP  = 5'd24;
  localparam logic [4:0] S_DONE = 5'd25;

  logic [4:0] state;
  logic [BKT_W:0] clr_cnt;
  logic [FILL_W-1:0] cap_reg;
  logic [NB_W-1:0] nbase;
  logic [BKT_W-1:0] split;
  logic [CNT_W-1:0] total;

  logic [1:0] op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [BKT_W-1:0] bkt;
  logic [FILL_W-1:0] fill_b;
  logic [FILL_W-1:0] lo;
  logic [FILL_W-1:0] hi;
  logic [FILL_W-1:0] mid;
  logic [FILL_W-1:0] pos;
  logic [FILL_W-1:0] j;
  logic [BKT_W-1:0] sp_prev;
  logic [BKT_W-1:0] sp_sec;
  logic [FILL_W-1:0] sp_end;
  logic [FILL_W-1:0] sp_i;
  logic [FILL_W-1:0] kept;
  logic [FILL_W-1:0] sec_cnt;
  logic [KEY_W-1:0] sk;
  logic [VAL_W-1:0] sv;
  logic after_split;
  logic [1:0] status_r;
  logic [VAL_W-1:0] vout_r;
  logic repl_r;

  logic div_start;
  logic [KEY_W-1:0] div_key;
  div_res_t div_res;

  logic k_we;
  logic v_we;
  logic [ADDR_W-1:0] kv_waddr;
  logic [KEY_W-1:0] k_wdata;
  logic [VAL_W-1:0] v_wdata;
  logic [ADDR_W-1:0] kv_raddr;
  logic [KEY_W-1:0] k_rd;
  logic [VAL_W-1:0] v_rd;
  logic f_we;
  logic [BKT_W-1:0] f_waddr;
  logic [FILL_W-1:0] f_wdata;
  logic [BKT_W-1:0] f_raddr;
  logic [FILL_W-1:0] f_rd;

  logic [FILL_W-1:0] cap;
  logic [NB_W-1:0] m_calc;
  logic [BKT_W-1:0] bkt_calc;
  logic [FILL_W:0] mid_sum;
  logic [NB_W:0] used_bkts;
  logic [NB_W-1:0] cfg_buckets;
  logic [FILL_W-1:0] f_rd_clamp;
  logic cfg_clear;

  lht_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_key), .divisor(nbase),
    .res(div_res)
  );

  lht_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(kv_waddr), .wdata(k_wdata), .raddr(kv_raddr),
    .rdata(k_rd)
  );

  lht_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_val_ram (
    .clk(clk), .we(v_we), .waddr(kv_waddr), .wdata(v_wdata), .raddr(kv_raddr),
    .rdata(v_rd)
  );

  lht_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BUCKETS)) u_fill_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr),
    .rdata(f_rd)
  );

  always_comb begin
    if (cap_reg == '0) begin
      cap = FILL_W'(1);
    end else if (cap_reg > FILL_W'(SLOTS)) begin
      cap = FILL_W'(SLOTS);
    end else begin
      cap = cap_reg;
    end
    if (cfg_data == '0) begin
      cfg_buckets = NB_W'(1);
    end else if (cfg_data > NB_W'(MAX_BUCKETS)) begin
      cfg_buckets = NB_W'(MAX_BUCKETS);
    end else begin
      cfg_buckets = cfg_data;
    end
    f_rd_clamp = (f_rd > FILL_W'(SLOTS)) ? FILL_W'(SLOTS) : f_rd;
    m_calc = div_res.rem;
    if (div_res.rem < {1'b0, split} && div_res.q_lsb) begin
      m_calc = div_res.rem + nbase;
    end
    bkt_calc = m_calc[BKT_W-1:0];
    mid_sum = {1'b0, lo} + {1'b0, hi};
    used_bkts = {1'b0, nbase} + {2'b0, split};
  end

  assign cfg_clear = cfg_we && (cfg_index == REG_INIT_BUCKETS);

  assign in_ch.ready = (state == S_IDLE) && !cfg_clear;
  assign out_ch.valid = (state == S_DONE);
  assign out_ch.status = status_r;
  assign out_ch.value_out = vout_r;
  assign out_ch.replaced = repl_r;
  assign out_ch.level_buckets = nbase;
  assign out_ch.split_pointer = split;
  assign out_ch.live_items = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      cap_reg <= RESET_CAPACITY;
      nbase <= RESET_BUCKETS;
      split <= '0;
      total <= '0;
      div_start <= 1'b0;
      k_we <= 1'b0;
      v_we <= 1'b0;
      f_we <= 1'b0;
    end else begin
      div_start <= 1'b0;
      k_we <= 1'b0;
      v_we <= 1'b0;
      f_we <= 1'b0;
      if (cfg_clear) begin
        nbase <= cfg_buckets;
        split <= '0;
        total <= '0;
        clr_cnt <= '0;
        state <= S_CLR;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_ch.valid) begin
              op_r <= in_ch.operation;
              key_r <= in_ch.key;
              val_r <= in_ch.value;
              status_r <= ST_OK;
              vout_r <= '0;
              repl_r <= 1'b0;
              after_split <= 1'b0;
              if (in_ch.operation == OP_PUT || in_ch.operation == OP_GET ||
                  in_ch.operation == OP_REMOVE) begin
                div_key <= in_ch.key;
                div_start <= 1'b1;
                state <= S_DIV;
              end else begin
                status_r <= ST_NOT_FOUND;
                state <= S_DONE;
              end
            end
          end
          S_CLR: begin
            f_we <= 1'b1;
            f_waddr <= clr_cnt[BKT_W-1:0];
            f_wdata <= '0;
            clr_cnt <= clr_cnt + 1'b1;
            if (clr_cnt == (BKT_W+1)'(MAX_BUCKETS - 1)) begin
              state <= S_IDLE;
            end
          end
          S_DIV: begin
            if (div_res.done) begin
              bkt <= bkt_calc;
              f_raddr <= bkt_calc;
              state <= S_FW;
            end
          end
          S_FW: begin
            state <= S_FCHK;
          end
          S_FCHK: begin
            fill_b <= f_rd;
            if (op_r == OP_PUT && !after_split && f_rd >= cap) begin
              if (used_bkts < (NB_W+1)'(MAX_BUCKETS)) begin
                sp_prev <= split;
                sp_sec <= nbase[BKT_W-1:0] + split;
                split <= split + 1'b1;
                f_raddr <= split;
                state <= S_SPFW;
              end else begin
                status_r <= ST_TABLE_FULL;
                state <= S_DONE;
              end
            end else begin
              lo <= '0;
              hi <= f_rd_clamp;
              state <= S_BSC;
            end
          end
          S_SPFW: begin
            state <= S_SPF;
          end
          S_SPF: begin
            sp_end <= f_rd_clamp;
            sp_i <= '0;
            kept <= '0;
            sec_cnt <= '0;
            state <= S_SPL;
          end
          S_SPL: begin
            if (sp_i == sp_end) begin
              f_we <= 1'b1;
              f_waddr <= sp_prev;
              f_wdata <= kept;
              state <= S_SPE;
            end else begin
              kv_raddr <= {sp_prev, sp_i[SLOT_W-1:0]};
              state <= S_SPW;
            end
          end
          S_SPW: begin
            state <= S_SPD;
          end
          S_SPD: begin
            sk <= k_rd;
            sv <= v_rd;
            div_key <= k_rd;
            div_start <= 1'b1;
            state <= S_SPDV;
          end
          S_SPDV: begin
            if (div_res.done) begin
              k_we <= 1'b1;
              v_we <= 1'b1;
              k_wdata <= sk;
              v_wdata <= sv;
              if (bkt_calc == sp_sec) begin
                kv_waddr <= {sp_sec, sec_cnt[SLOT_W-1:0]};
                sec_cnt <= sec_cnt + 1'b1;
              end else begin
                kv_waddr <= {sp_prev, kept[SLOT_W-1:0]};
                kept <= kept + 1'b1;
              end
              sp_i <= sp_i + 1'b1;
              state <= S_SPL;
            end
          end
          S_SPE: begin
            f_we <= 1'b1;
            f_waddr <= sp_sec;
            f_wdata <= sec_cnt;
            if ({1'b0, split} >= nbase) begin
              split <= '0;
              nbase <= {nbase[NB_W-2:0], 1'b0};
            end
            div_key <= key_r;
            div_start <= 1'b1;
            after_split <= 1'b1;
            state <= S_DIV;
          end
          S_BSC: begin
            if (lo < hi) begin
              mid <= mid_sum[FILL_W:1];
              kv_raddr <= {bkt, mid_sum[SLOT_W:1]};
              state <= S_BSW;
            end else begin
              state <= S_NF;
            end
          end
          S_BSW: begin
            state <= S_BSM;
          end
          S_BSM: begin
            if (k_rd == key_r) begin
              pos <= mid;
              state <= S_FND;
            end else begin
              if (k_rd < key_r) begin
                lo <= mid + 1'b1;
              end else begin
                hi <= mid;
              end
              state <= S_BSC;
            end
          end
          S_FND: begin
            if (op_r == OP_PUT) begin
              v_we <= 1'b1;
              kv_waddr <= {bkt, pos[SLOT_W-1:0]};
              v_wdata <= val_r;
              repl_r <= 1'b1;
              state <= S_DONE;
            end else begin
              kv_raddr <= {bkt, pos[SLOT_W-1:0]};
              state <= S_GW;
            end
          end
          S_GW: begin
            state <= S_GR;
          end
          S_GR: begin
            vout_r <= v_rd;
            if (op_r == OP_REMOVE) begin
              fill_b <= fill_b - 1'b1;
              state <= S_RML;
            end else begin
              state <= S_DONE;
            end
          end
          S_RML: begin
            if (pos < fill_b && pos < FILL_W'(SLOTS - 1)) begin
              kv_raddr <= {bkt, SLOT_W'(pos + 1'b1)};
              state <= S_RMW;
            end else begin
              f_we <= 1'b1;
              f_waddr <= bkt;
              f_wdata <= fill_b;
              if (total != '0) begin
                total <= total - 1'b1;
              end
              state <= S_DONE;
            end
          end
          S_RMW: begin
            state <= S_RMP;
          end
          S_RMP: begin
            k_we <= 1'b1;
            v_we <= 1'b1;
            kv_waddr <= {bkt, pos[SLOT_W-1:0]};
            k_wdata <= k_rd;
            v_wdata <= v_rd;
            pos <= pos + 1'b1;
            state <= S_RML;
          end
          S_NF: begin
            if (op_r == OP_PUT) begin
              if (fill_b >= cap) begin
                status_r <= ST_OVERFLOW;
                state <= S_DONE;
              end else begin
                j <= fill_b;
                state <= S_INL;
              end
            end else begin
              status_r <= ST_NOT_FOUND;
              state <= S_DONE;
            end
          end
          S_INL: begin
            if (j > lo) begin
              kv_raddr <= {bkt, SLOT_W'(j - 1'b1)};
              state <= S_INW;
            end else begin
              k_we <= 1'b1;
              v_we <= 1'b1;
              kv_waddr <= {bkt, lo[SLOT_W-1:0]};
              k_wdata <= key_r;
              v_wdata <= val_r;
              f_we <= 1'b1;
              f_waddr <= bkt;
              f_wdata <= fill_b + 1'b1;
              total <= total + 1'b1;
              state <= S_DONE;
            end
          end
          S_INW: begin
            state <= S_INP;
          end
          S_INP: begin
            k_we <= 1'b1;
            v_we <= 1'b1;
            kv_waddr <= {bkt, j[SLOT_W-1:0]};
            k_wdata <= k_rd;
            v_wdata <= v_rd;
            j <= j - 1'b1;
            state <= S_INL;
          end
          S_DONE: begin
            if (out_ch.ready) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
      if (cfg_we && cfg_index == REG_CAPACITY) begin
        cap_reg <= cfg_data[FILL_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire
